// ===== design/mce_pkg.sv =====
// Shared types and constants for the missing-columns encoder.
// No dependencies; used by mce_ctrl, mce_datapath and missing_columns_encoder.
`default_nettype none

package mce_pkg;

    localparam int CFG_W           = 11;
    localparam int VALUE_W         = 63;
    localparam int STATUS_W        = 2;
    localparam int SMALL_LIMIT     = 64;
    localparam int BITMAP_W        = 63;
    localparam int MAX_COLUMNS_DEF = 1024;

    typedef enum logic [STATUS_W-1:0] {
        ST_VALID      = 2'd0,
        ST_END        = 2'd1,
        ST_NOT_LOADED = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        VAL_ZERO   = 2'd0,
        VAL_BITMAP = 2'd1,
        VAL_COUNT  = 2'd2,
        VAL_ID     = 2'd3
    } t_val_sel;

    typedef enum logic [1:0] {
        S_IDLE     = 2'd0,
        S_SCAN_RD  = 2'd1,
        S_SCAN_CHK = 2'd2
    } t_state;

    typedef struct packed {
        logic     load;
        logic     clear;
        logic     set_cnt_emitted;
        logic     scan_inc;
        logic     emit;
        t_val_sel emit_sel;
        t_status  emit_status;
    } t_dp_cmd;

    typedef struct packed {
        logic loaded;
        logic all_present;
        logic narrow;
        logic cnt_emitted;
        logic scan_done;
        logic bit_match;
    } t_dp_stat;

endpackage

`default_nettype wire

// ===== design/mce_ctrl.sv =====
// Sequencer for the missing-columns encoder: accepts beats, decides each request
// and steps the id scan. Depends on mce_pkg; drives mce_datapath via t_dp_cmd.
`default_nettype none

module mce_ctrl (
    input  wire                logic i_clk,
    input  wire                logic i_rst_n,
    input  wire                logic start,
    input  wire                logic i_mode,
    input  wire mce_pkg::t_dp_stat i_stat,
    output logic               busy,
    output mce_pkg::t_dp_cmd   o_cmd
);

    mce_pkg::t_state r_state;
    mce_pkg::t_state n_state;
    logic            accept;

    assign accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mce_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            mce_pkg::S_IDLE: begin
                if (accept && i_mode && i_stat.loaded && !i_stat.all_present &&
                    !i_stat.narrow && i_stat.cnt_emitted) begin
                    n_state = mce_pkg::S_SCAN_RD;
                end
            end
            mce_pkg::S_SCAN_RD: begin
                n_state = i_stat.scan_done ? mce_pkg::S_IDLE : mce_pkg::S_SCAN_CHK;
            end
            mce_pkg::S_SCAN_CHK: begin
                n_state = i_stat.bit_match ? mce_pkg::S_IDLE : mce_pkg::S_SCAN_RD;
            end
            default: n_state = mce_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        busy                  = (r_state != mce_pkg::S_IDLE);
        o_cmd                 = '0;
        o_cmd.emit_sel        = mce_pkg::VAL_ZERO;
        o_cmd.emit_status     = mce_pkg::ST_VALID;
        case (r_state)
            mce_pkg::S_IDLE: begin
                if (accept && !i_mode) begin
                    o_cmd.load = !i_stat.loaded;
                end else if (accept && i_mode) begin
                    if (!i_stat.loaded) begin
                        o_cmd.emit        = 1'b1;
                        o_cmd.emit_status = mce_pkg::ST_NOT_LOADED;
                    end else if (i_stat.all_present ||
                                 (i_stat.narrow && i_stat.cnt_emitted)) begin
                        o_cmd.clear       = 1'b1;
                        o_cmd.emit        = 1'b1;
                        o_cmd.emit_status = mce_pkg::ST_END;
                    end else if (!i_stat.cnt_emitted) begin
                        // first value: bitmap for narrow rows, missing count otherwise
                        o_cmd.set_cnt_emitted = 1'b1;
                        o_cmd.emit            = 1'b1;
                        o_cmd.emit_sel        = i_stat.narrow ? mce_pkg::VAL_BITMAP
                                                              : mce_pkg::VAL_COUNT;
                    end
                end
            end
            mce_pkg::S_SCAN_RD: begin
                if (i_stat.scan_done) begin
                    o_cmd.clear       = 1'b1;
                    o_cmd.emit        = 1'b1;
                    o_cmd.emit_status = mce_pkg::ST_END;
                end
            end
            mce_pkg::S_SCAN_CHK: begin
                o_cmd.scan_inc = 1'b1;
                if (i_stat.bit_match) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.emit_sel = mce_pkg::VAL_ID;
                end
            end
            default: begin
                o_cmd.emit = 1'b0;
            end
        endcase
    end

    a_chk_after_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mce_pkg::S_SCAN_CHK) |-> ($past(r_state) == mce_pkg::S_SCAN_RD))
        else $error("scan check without a preceding read");

    a_no_load_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> (!o_cmd.emit && !o_cmd.clear))
        else $error("load issued together with a result");

endmodule

`default_nettype wire

// ===== design/mce_datapath.sv =====
// Row state, presence memory and result registers of the missing-columns encoder.
// Depends on mce_pkg; commanded by mce_ctrl through t_dp_cmd.
`default_nettype none

module mce_datapath #(
    parameter int MAX_COLUMNS = mce_pkg::MAX_COLUMNS_DEF
) (
    input  wire              logic i_clk,
    input  wire              logic i_rst_n,
    input  wire              logic i_cfg_we,
    input  wire              logic [mce_pkg::CFG_W-1:0] i_cfg_data,
    input  wire              logic i_column_present,
    input  wire mce_pkg::t_dp_cmd i_cmd,
    output mce_pkg::t_dp_stat o_stat,
    output logic             o_strobe,
    output logic [mce_pkg::VALUE_W-1:0]  o_value,
    output logic [mce_pkg::STATUS_W-1:0] o_status
);

    localparam int CNT_W  = $clog2(MAX_COLUMNS + 1);
    localparam int ADDR_W = $clog2(MAX_COLUMNS);
    localparam int CMP_W  = (CNT_W > mce_pkg::CFG_W) ? CNT_W : mce_pkg::CFG_W;

    logic                          r_mem [MAX_COLUMNS];
    logic                          r_rd_bit;
    logic [CNT_W-1:0]              r_total;
    logic [CNT_W-1:0]              r_load_idx;
    logic [CNT_W-1:0]              r_present_cnt;
    logic [CNT_W-1:0]              r_scan;
    logic [mce_pkg::BITMAP_W-1:0]  r_bitmap;
    logic                          r_cnt_emitted;
    logic                          r_strobe;
    logic [mce_pkg::VALUE_W-1:0]   r_value;
    logic [mce_pkg::STATUS_W-1:0]  r_status;

    logic [CNT_W-1:0]              n_total;
    logic [mce_pkg::VALUE_W-1:0]   n_value;
    logic                          list_present;
    logic                          do_load;

    // clamp the configured count to the store depth
    assign n_total = (CMP_W'(i_cfg_data) < CMP_W'(MAX_COLUMNS)) ? CNT_W'(i_cfg_data)
                                                                 : CNT_W'(MAX_COLUMNS);

    assign do_load      = i_cmd.load && (r_load_idx < r_total);
    assign list_present = r_present_cnt < (r_total >> 1);

    always_comb begin
        o_stat.loaded      = (r_load_idx >= r_total);
        o_stat.all_present = (r_present_cnt >= r_total);
        o_stat.narrow      = (r_total < CNT_W'(mce_pkg::SMALL_LIMIT));
        o_stat.cnt_emitted = r_cnt_emitted;
        o_stat.scan_done   = (r_scan >= r_total);
        o_stat.bit_match   = (list_present == r_rd_bit);
    end

    always_comb begin
        case (i_cmd.emit_sel)
            mce_pkg::VAL_BITMAP: n_value = mce_pkg::VALUE_W'(r_bitmap);
            mce_pkg::VAL_COUNT:  n_value = mce_pkg::VALUE_W'(r_total - r_present_cnt);
            mce_pkg::VAL_ID:     n_value = mce_pkg::VALUE_W'(r_scan);
            default:             n_value = '0;
        endcase
    end

    // presence store: one write port for loads, one registered read at the scan pointer
    always_ff @(posedge i_clk) begin
        if (do_load) begin
            r_mem[r_load_idx[ADDR_W-1:0]] <= i_column_present;
        end
        r_rd_bit <= r_mem[r_scan[ADDR_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total       <= '0;
            r_load_idx    <= '0;
            r_present_cnt <= '0;
            r_scan        <= '0;
            r_bitmap      <= '0;
            r_cnt_emitted <= 1'b0;
            r_strobe      <= 1'b0;
        end else begin
            r_strobe <= i_cmd.emit;
            if (i_cfg_we || i_cmd.clear) begin
                r_load_idx    <= '0;
                r_present_cnt <= '0;
                r_scan        <= '0;
                r_bitmap      <= '0;
                r_cnt_emitted <= 1'b0;
            end else begin
                if (do_load) begin
                    r_load_idx <= r_load_idx + 1'b1;
                    if (i_column_present) begin
                        r_present_cnt <= r_present_cnt + 1'b1;
                    end else if (r_load_idx < CNT_W'(mce_pkg::BITMAP_W)) begin
                        r_bitmap[r_load_idx[5:0]] <= 1'b1;
                    end
                end
                if (i_cmd.set_cnt_emitted) begin
                    r_cnt_emitted <= 1'b1;
                end
                if (i_cmd.scan_inc) begin
                    r_scan <= r_scan + 1'b1;
                end
            end
            if (i_cfg_we) begin
                r_total <= n_total;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_value  <= n_value;
            r_status <= i_cmd.emit_status;
        end
    end

    assign o_strobe = r_strobe;
    assign o_value  = r_value;
    assign o_status = r_status;

    a_load_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_load_idx <= r_total)
        else $error("load index ran past the column count");

    a_present_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_present_cnt <= r_load_idx)
        else $error("present count exceeds loaded columns");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_scan <= r_total)
        else $error("scan pointer ran past the column count");

endmodule

`default_nettype wire

// ===== design/missing_columns_encoder.sv =====
// Top level of the missing-columns encoder.
// Depends on mce_pkg, mce_ctrl and mce_datapath.
`default_nettype none

// Usage
//   Command beats: raise start with i_mode/i_column_present; the beat is taken
//   at a rising edge with start high and busy low. i_mode = 0 loads the
//   presence bit of the next column (no result); i_mode = 1 asks for the next
//   value of the encoding, which appears on o_value/o_status for one cycle
//   with o_strobe high.
//   Column count: write i_cfg_data with i_cfg_we high while idle; this also
//   clears the row.
//   Loads never raise busy. A request answers in the cycle after it is taken,
//   except a column-id request, which walks the presence memory one column at
//   a time, a read state then a check state per column (one read port,
//   registered read): it answers with the id of the first column examined
//   that matches, or with the end-of-row result when the scan runs out.
//   Busy stays high until the strobe cycle.
//   Reset (synchronous, active low): column count 0, row cleared, no strobe.
//   The presence memory is not cleared; only bits loaded since the last
//   clear are read.
//   The receiver cannot stall: each result is valid for exactly one cycle.

module missing_columns_encoder #(
    parameter int MAX_COLUMNS = mce_pkg::MAX_COLUMNS_DEF
) (
    input  wire  logic                          i_clk,
    input  wire  logic                          i_rst_n,
    input  wire  logic                          i_cfg_we,
    input  wire  logic [mce_pkg::CFG_W-1:0]     i_cfg_data,
    input  wire  logic                          start,
    output logic                                busy,
    input  wire  logic                          i_mode,
    input  wire  logic                          i_column_present,
    output logic                                o_strobe,
    output logic [mce_pkg::VALUE_W-1:0]         o_value,
    output logic [mce_pkg::STATUS_W-1:0]        o_status
);

    mce_pkg::t_dp_cmd  cmd;
    mce_pkg::t_dp_stat stat;

    mce_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_mode  (i_mode),
        .i_stat  (stat),
        .busy    (busy),
        .o_cmd   (cmd)
    );

    mce_datapath #(
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_data       (i_cfg_data),
        .i_column_present (i_column_present),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .o_strobe         (o_strobe),
        .o_value          (o_value),
        .o_status         (o_status)
    );

endmodule

`default_nettype wire

// ===== bench/missing_columns_encoder_test.sv =====
// Self-checking bench for missing_columns_encoder: column loads, encoded-value
// requests and column-count writes, checked against a predictor of the encoding.
// Depends on mce_pkg and the missing_columns_encoder RTL.

module missing_columns_encoder_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_COLS     = mce_pkg::MAX_COLUMNS_DEF;
    localparam int COL_IDX_W    = $clog2(MAX_COLS);
    localparam int MAP_IDX_W    = $clog2(mce_pkg::BITMAP_W);
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int REPORT_LIMIT = 10;
    localparam int DRAIN_CYCLES = 8;

    localparam bit MODE_LOAD    = 1'b0;
    localparam bit MODE_REQUEST = 1'b1;

    typedef enum logic [1:0] {
        LIST_BITMAP      = 2'd0,
        LIST_PRESENT_IDS = 2'd1,
        LIST_MISSING_IDS = 2'd2
    } t_list_kind;

    typedef struct packed {
        logic [mce_pkg::VALUE_W-1:0] value;
        mce_pkg::t_status            status;
    } t_enc_word;

    logic                         i_clk            = 1'b0;
    logic                         i_rst_n          = 1'b0;
    logic                         i_cfg_we         = 1'b0;
    logic [mce_pkg::CFG_W-1:0]    i_cfg_data       = '0;
    logic                         start            = 1'b0;
    logic                         i_mode           = 1'b0;
    logic                         i_column_present = 1'b0;
    logic                         busy;
    logic                         o_strobe;
    logic [mce_pkg::VALUE_W-1:0]  o_value;
    logic [mce_pkg::STATUS_W-1:0] o_status;

    missing_columns_encoder #(
        .MAX_COLUMNS(MAX_COLS)
    ) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .start           (start),
        .busy            (busy),
        .i_mode          (i_mode),
        .i_column_present(i_column_present),
        .o_strobe        (o_strobe),
        .o_value         (o_value),
        .o_status        (o_status)
    );

    always #4 i_clk = ~i_clk;

    // Predictor state
    logic [mce_pkg::CFG_W-1:0]    column_setting = '0;
    logic [MAX_COLS-1:0]          cell_seen      = '0;
    logic [mce_pkg::BITMAP_W-1:0] missing_map    = '0;
    int unsigned                  loaded_cols    = 0;
    int unsigned                  present_cols   = 0;
    int unsigned                  next_scan      = 0;
    bit                           head_sent      = 1'b0;
    bit                           row_closed     = 1'b0;

    t_enc_word   pending_words[$];
    int unsigned useful_beats    = 0;
    int unsigned fail_count      = 0;
    int unsigned cycle_count     = 0;
    int unsigned sender_idle_pct = 0;

    function automatic int unsigned active_columns();
        return (32'(column_setting) < MAX_COLS) ? 32'(column_setting) : MAX_COLS;
    endfunction

    function automatic void clear_row_model();
        missing_map  = '0;
        loaded_cols  = 0;
        present_cols = 0;
        next_scan    = 0;
        head_sent    = 1'b0;
    endfunction

    // Advance the predictor by one accepted beat; returns 1 when a result is due.
    function automatic bit encode_beat(input bit mode, input bit present,
                                       output t_enc_word word);
        int unsigned cols;
        int unsigned scan_idx;
        t_list_kind  kind;
        cols        = active_columns();
        word.value  = '0;
        word.status = mce_pkg::ST_VALID;
        if (mode == MODE_LOAD) begin
            if (loaded_cols < cols) begin
                cell_seen[loaded_cols[COL_IDX_W-1:0]] = present;
                if (present)
                    present_cols++;
                else if (loaded_cols < mce_pkg::BITMAP_W)
                    missing_map[loaded_cols[MAP_IDX_W-1:0]] = 1'b1;
                loaded_cols++;
                useful_beats++;
            end
            return 1'b0;
        end
        useful_beats++;
        if (loaded_cols < cols) begin
            word.status = mce_pkg::ST_NOT_LOADED;
            return 1'b1;
        end
        if (present_cols < cols) begin
            if (cols < mce_pkg::SMALL_LIMIT)
                kind = LIST_BITMAP;
            else if (present_cols < cols / 2)
                kind = LIST_PRESENT_IDS;
            else
                kind = LIST_MISSING_IDS;
            if (!head_sent) begin
                head_sent = 1'b1;
                if (kind == LIST_BITMAP)
                    word.value = missing_map;
                else
                    word.value = mce_pkg::VALUE_W'(cols - present_cols);
                return 1'b1;
            end
            if (kind != LIST_BITMAP) begin
                while (next_scan < cols) begin
                    scan_idx = next_scan;
                    next_scan++;
                    if (cell_seen[scan_idx[COL_IDX_W-1:0]] == (kind == LIST_PRESENT_IDS)) begin
                        word.value = mce_pkg::VALUE_W'(scan_idx);
                        return 1'b1;
                    end
                end
            end
        end
        // Nothing left to list: close the row
        clear_row_model();
        row_closed  = 1'b1;
        word.status = mce_pkg::ST_END;
        return 1'b1;
    endfunction

    function automatic void note_failure(input string msg);
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
            $display("%0t: %s", $time, msg);
    endfunction

    always @(posedge i_clk) begin : check_result
        t_enc_word want;
        if (i_rst_n && o_strobe) begin
            if (pending_words.size() == 0) begin
                note_failure($sformatf("unexpected result: value=%0h status=%0d",
                                       o_value, o_status));
            end else begin
                want = pending_words.pop_front();
                if (o_value !== want.value || o_status !== want.status)
                    note_failure($sformatf(
                        "result mismatch: expected value=%0h status=%0d, got value=%0h status=%0d",
                        want.value, want.status, o_value, o_status));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Offer one beat, with an optional gap first; hold it until busy drops.
    task automatic send_beat(input bit mode, input bit present);
        t_enc_word word;
        if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
            @(negedge i_clk);
            start = 1'b0;
            repeat ($urandom_range(4)) @(negedge i_clk);
        end
        @(negedge i_clk);
        start            = 1'b1;
        i_mode           = mode;
        i_column_present = present;
        do @(posedge i_clk); while (busy);
        if (encode_beat(mode, present, word))
            pending_words = {pending_words, word};
    endtask

    task automatic drain_pending();
        @(negedge i_clk);
        start = 1'b0;
        while (pending_words.size() != 0) @(posedge i_clk);
        // loads raise no result, so keep waiting for DRAIN_CYCLES after the queue empties
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_column_count(input int unsigned n);
        drain_pending();
        @(negedge i_clk);
        i_cfg_we       = 1'b1;
        i_cfg_data     = n[mce_pkg::CFG_W-1:0];
        column_setting = n[mce_pkg::CFG_W-1:0];
        clear_row_model();
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // Load one row with an exact number of present columns, then request
    // values until the row closes. A broken row stops part-way through loading.
    task automatic run_row(input int present_goal, input bit broken);
        int unsigned cols, i, guard, cut;
        int          want;
        bit          p;
        cols = active_columns();
        want = present_goal;
        if (want < 0) begin
            case ($urandom_range(7))
                0:       want = 0;
                1:       want = cols;
                2:       want = int'(cols) - 1;
                3:       want = 1;
                4:       want = cols / 2;
                5:       want = int'(cols / 2) - 1;
                6:       want = cols / 2 + 1;
                default: want = $urandom_range(cols);
            endcase
        end
        if (want < 0)
            want = 0;
        if (want > int'(cols))
            want = cols;
        cut        = (cols != 0) ? $urandom_range(cols - 1) : 0;
        broken     = broken && (cols != 0);
        row_closed = 1'b0;
        for (i = 0; i < cols; i++) begin
            if (broken && i == cut) begin
                if ($urandom_range(1))
                    send_beat(MODE_REQUEST, 1'($urandom_range(1)));
                return;
            end
            if ($urandom_range(99) < 4)
                send_beat(MODE_REQUEST, 1'($urandom_range(1)));
            p = (int'($urandom_range(cols - i - 1)) < want);
            if (p)
                want--;
            send_beat(MODE_LOAD, p);
        end
        // loads past the column count are dropped
        if ($urandom_range(99) < 25)
            repeat ($urandom_range(1, 3)) send_beat(MODE_LOAD, 1'($urandom_range(1)));
        guard = 0;
        while (!row_closed && guard < 2 * MAX_COLS + 8) begin
            if ($urandom_range(99) < 5)
                send_beat(MODE_LOAD, 1'($urandom_range(1)));
            send_beat(MODE_REQUEST, 1'($urandom_range(1)));
            guard++;
        end
    endtask

    task automatic test_short_rows();
        // empty schema: the first request closes the row at once
        send_beat(MODE_REQUEST, 1'b0);
        send_beat(MODE_LOAD, 1'b1);

        set_column_count(3);
        send_beat(MODE_REQUEST, 1'b1);
        send_beat(MODE_LOAD, 1'b1);
        send_beat(MODE_LOAD, 1'b0);
        send_beat(MODE_LOAD, 1'b1);
        send_beat(MODE_LOAD, 1'b0);
        send_beat(MODE_REQUEST, 1'b0);
        send_beat(MODE_LOAD, 1'b1);
        send_beat(MODE_REQUEST, 1'b1);

        // a column-count write drops the half-loaded row
        set_column_count(2);
        send_beat(MODE_LOAD, 1'b0);
        set_column_count(2);
        send_beat(MODE_LOAD, 1'b1);
        send_beat(MODE_LOAD, 1'b1);
        send_beat(MODE_REQUEST, 1'b0);

        set_column_count(1);
        send_beat(MODE_LOAD, 1'b0);
        send_beat(MODE_REQUEST, 1'b0);
        send_beat(MODE_REQUEST, 1'b1);
    endtask

    task automatic test_random_rows(input int unsigned idle_pct,
                                    input int unsigned beat_goal);
        int unsigned first_beat, ncols, r;
        bit          broken, fresh;
        sender_idle_pct = idle_pct;
        first_beat      = useful_beats;
        fresh           = 1'b1;
        while (useful_beats - first_beat < beat_goal) begin
            r = $urandom_range(19);
            if (r < 3) begin
                case ($urandom_range(7))
                    0:       ncols = 0;
                    1:       ncols = 1;
                    2:       ncols = 2;
                    3:       ncols = mce_pkg::SMALL_LIMIT - 2;
                    4:       ncols = mce_pkg::SMALL_LIMIT - 1;
                    5:       ncols = mce_pkg::SMALL_LIMIT;
                    6:       ncols = mce_pkg::SMALL_LIMIT + 1;
                    default: ncols = 2 * mce_pkg::SMALL_LIMIT - 1;
                endcase
            end else if (r < 14) begin
                ncols = $urandom_range(1, mce_pkg::SMALL_LIMIT - 1);
            end else begin
                ncols = $urandom_range(mce_pkg::SMALL_LIMIT, 200);
            end
            if (fresh || $urandom_range(1))
                set_column_count(ncols);
            broken = ($urandom_range(99) < 8);
            run_row(-1, broken);
            // a broken row leaves state behind; rewrite the count to clear it
            fresh = broken;
        end
    endtask

    task automatic test_widest_row();
        set_column_count(MAX_COLS - 1);
        repeat (5) send_beat(MODE_LOAD, 1'($urandom_range(1)));
        send_beat(MODE_REQUEST, 1'b0);

        set_column_count(MAX_COLS);
        run_row(MAX_COLS - int'($urandom_range(3, 10)), 1'b0);
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_short_rows();
        test_random_rows(31, 200);
        test_random_rows(73, 200);
        test_random_rows(0, 200);
        test_widest_row();

        drain_pending();
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
